// ----- rtl/plist_pkg.sv -----
// ----------------------------------------------------------------------------
// plist_pkg
// Shared types and constants for the positional ordered list.
// ----------------------------------------------------------------------------
`default_nettype none

package plist_pkg;

    // Capacity of the list and the widths that follow from it.
    localparam int DEPTH = 32;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);

    // Field widths of the stream items.
    localparam int CMD_W = 3;
    localparam int VAL_W = 32;
    localparam int POS_W = 6;
    localparam int ST_W  = 2;
    localparam int LEN_W = 6;

    // Width wide enough to compare a position against count plus one.
    localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    typedef enum logic [CMD_W-1:0] {
        CMD_INS_FRONT = 3'd0,
        CMD_INS_BACK  = 3'd1,
        CMD_INS_AT    = 3'd2,
        CMD_DEL_FRONT = 3'd3,
        CMD_DEL_BACK  = 3'd4,
        CMD_DEL_AT    = 3'd5,
        CMD_DUMP      = 3'd6
    } cmd_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic do_op;      // apply the list operation and load its result
        logic do_emit;    // load the front entry as a dump beat and rotate
        logic emit_last;  // the emitted beat closes the dump
    } ctl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic             count_zero;
        logic [CNT_W-1:0] count;
    } stat_t;

endpackage

`default_nettype wire

// ----- rtl/plist_dpath.sv -----
// ----------------------------------------------------------------------------
// plist_dpath
// Shifting cell file, entry count and result register of the list.
// ----------------------------------------------------------------------------
`default_nettype none

module plist_dpath
    import plist_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire ctl_t                    ctl,
    input  wire cmd_t                    cmd,
    input  wire logic signed [VAL_W-1:0] value,
    input  wire logic [POS_W-1:0]        position,
    output stat_t                        stat,
    output status_t                      res_status,
    output logic signed [VAL_W-1:0]      res_entry,
    output logic [LEN_W-1:0]             res_length,
    output logic                         res_last
);

    logic signed [VAL_W-1:0] cells_reg  [DEPTH];
    logic signed [VAL_W-1:0] cells_next [DEPTH];
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;

    status_t                 status_reg;
    logic signed [VAL_W-1:0] entry_reg;
    logic [LEN_W-1:0]        length_reg;
    logic                    last_reg;

    status_t          op_status;
    logic             ins_ok;
    logic             del_ok;
    logic [IDX_W-1:0] op_idx;
    logic             ins_en;
    logic             del_en;
    logic             rot_en;
    logic             full;
    logic             empty;
    logic [CMP_W-1:0] pos_w;
    logic [CMP_W-1:0] cnt_w;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign pos_w = CMP_W'(position);
    assign cnt_w = CMP_W'(count_reg);

    // Decode the command into a status and the cell index it acts on.
    always_comb
    begin
        op_status = ST_OK;
        ins_ok    = 1'b0;
        del_ok    = 1'b0;
        op_idx    = '0;
        unique case (cmd)
            CMD_INS_FRONT:
            begin
                if (full) op_status = ST_FULL;
                else ins_ok = 1'b1;
            end
            CMD_INS_BACK:
            begin
                op_idx = IDX_W'(count_reg);
                if (full) op_status = ST_FULL;
                else ins_ok = 1'b1;
            end
            CMD_INS_AT:
            begin
                op_idx = IDX_W'(pos_w - CMP_W'(1));
                if (full) op_status = ST_FULL;
                else if (pos_w == '0 || pos_w > cnt_w + CMP_W'(1)) op_status = ST_RANGE;
                else ins_ok = 1'b1;
            end
            CMD_DEL_FRONT:
            begin
                if (empty) op_status = ST_EMPTY;
                else del_ok = 1'b1;
            end
            CMD_DEL_BACK:
            begin
                op_idx = IDX_W'(cnt_w - CMP_W'(1));
                if (empty) op_status = ST_EMPTY;
                else del_ok = 1'b1;
            end
            CMD_DEL_AT:
            begin
                op_idx = IDX_W'(pos_w - CMP_W'(1));
                if (empty) op_status = ST_EMPTY;
                else if (pos_w == '0 || pos_w > cnt_w) op_status = ST_RANGE;
                else del_ok = 1'b1;
            end
            CMD_DUMP:
            begin
                if (empty) op_status = ST_EMPTY;
            end
            default:
            begin
                op_status = ST_OK;
            end
        endcase
    end

    assign ins_en = ctl.do_op & ins_ok;
    assign del_en = ctl.do_op & del_ok;
    assign rot_en = ctl.do_emit;

    always_comb
    begin
        count_next = count_reg;
        if (ins_en) count_next = count_reg + CNT_W'(1);
        else if (del_en) count_next = count_reg - CNT_W'(1);
    end

    // Each cell picks its own next value from itself or a neighbor. A dump
    // rotates the occupied cells by one place per beat, so after count beats
    // the list is back in its original order.
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        localparam int PREV = (g == 0) ? 0 : g - 1;
        localparam int NEXT = (g == DEPTH - 1) ? g : g + 1;

        always_comb
        begin
            cells_next[g] = cells_reg[g];
            if (ins_en)
            begin
                if (IDX_W'(g) == op_idx) cells_next[g] = value;
                else if (IDX_W'(g) > op_idx) cells_next[g] = cells_reg[PREV];
            end
            else if (del_en)
            begin
                if (IDX_W'(g) >= op_idx) cells_next[g] = cells_reg[NEXT];
            end
            else if (rot_en)
            begin
                if (CNT_W'(g + 1) == count_reg) cells_next[g] = cells_reg[0];
                else cells_next[g] = cells_reg[NEXT];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            cells_reg[i] <= cells_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.do_op)
        begin
            status_reg <= op_status;
            entry_reg  <= '0;
            length_reg <= LEN_W'(count_next);
            last_reg   <= 1'b1;
        end
        else if (ctl.do_emit)
        begin
            status_reg <= ST_OK;
            entry_reg  <= cells_reg[0];
            length_reg <= LEN_W'(count_reg);
            last_reg   <= ctl.emit_last;
        end
    end

    assign stat.count_zero = empty;
    assign stat.count      = count_reg;
    assign res_status      = status_reg;
    assign res_entry       = entry_reg;
    assign res_length      = length_reg;
    assign res_last        = last_reg;

endmodule

`default_nettype wire

// ----- rtl/plist_ctrl.sv -----
// ----------------------------------------------------------------------------
// plist_ctrl
// Command sequencer: takes items, steps dumps and owns the output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module plist_ctrl
    import plist_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  s_tvalid,
    output logic       s_tready,
    input  wire cmd_t  cmd,
    output logic       m_tvalid,
    input  wire logic  m_tready,
    output ctl_t       ctl,
    input  wire stat_t stat
);

    typedef enum logic {
        S_IDLE,
        S_DUMP
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic             m_valid_reg;
    logic             m_valid_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic             out_free;

    // The result register can be loaded when empty or emptied this cycle.
    assign out_free = !m_valid_reg || m_tready;

    always_comb
    begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg & ~m_tready;
        idx_next     = idx_reg;
        ctl          = '0;
        s_tready     = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = out_free;
                if (s_tvalid && out_free)
                begin
                    if (cmd == CMD_DUMP && !stat.count_zero)
                    begin
                        state_next = S_DUMP;
                        idx_next   = '0;
                    end
                    else
                    begin
                        ctl.do_op    = 1'b1;
                        m_valid_next = 1'b1;
                    end
                end
            end
            S_DUMP:
            begin
                if (out_free)
                begin
                    ctl.do_emit   = 1'b1;
                    ctl.emit_last = ((CNT_W'(idx_reg) + CNT_W'(1)) == stat.count);
                    m_valid_next  = 1'b1;
                    idx_next      = idx_reg + IDX_W'(1);
                    if (ctl.emit_last) state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            idx_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            idx_reg     <= idx_next;
        end
    end

    assign m_tvalid = m_valid_reg;

    // A dump only runs over a list that holds entries.
    a_dump_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DUMP |-> !stat.count_zero)
        else $error("dump running over an empty list");

    // The closing beat of a dump returns the sequencer to idle.
    a_dump_ends: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.do_emit && ctl.emit_last |=> state_reg == S_IDLE)
        else $error("dump did not end after its last beat");

    // The result register is never loaded twice in one cycle.
    a_one_load: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.do_op && ctl.do_emit))
        else $error("operation and dump beat loaded together");

    // Any load of the result register presents a beat in the next cycle.
    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.do_op || ctl.do_emit |=> m_tvalid)
        else $error("loaded result not presented");

    // The entry count is left unchanged while a dump is under way.
    a_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DUMP && $past(state_reg) == S_DUMP |-> $stable(stat.count))
        else $error("count changed during a dump");

endmodule

`default_nettype wire

// ----- rtl/positional_ordered_list.sv -----
// ----------------------------------------------------------------------------
// positional_ordered_list
// Bounded ordered list with positional insert and delete and an ordered dump.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  tdata                          tuser          tlast
//  s_*      in   value[31:0], position[37:32]   cmd[2:0]       -
//  m_*      out  entry[31:0], length[37:32]     status[1:0]    last
//
//  An insert or delete answers with one beat; every cell shifts in
//  parallel. A dump first enters its dump state and then gives one beat
//  per entry, while the cells rotate through the front cell.
//  Reset clears the count and the control state; the cells hold no reset.
//  A stalled output beat holds the block back only while it is not taken.
//
// ----------------------------------------------------------------------------
`default_nettype none

module positional_ordered_list
    import plist_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // value, position, zero fill
    input  wire logic [2:0]  s_tuser,   // cmd
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // entry, length, zero fill
    output logic [1:0]       m_tuser,   // status
    output logic             m_tlast
);

    ctl_t                    ctl;
    stat_t                   stat;
    cmd_t                    cmd;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        position;
    status_t                 res_status;
    logic signed [VAL_W-1:0] res_entry;
    logic [LEN_W-1:0]        res_length;
    logic                    res_last;

    assign cmd      = cmd_t'(s_tuser[CMD_W-1:0]);
    assign value    = s_tdata[VAL_W-1:0];
    assign position = s_tdata[VAL_W+POS_W-1:VAL_W];

    plist_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .ctl      (ctl),
        .stat     (stat)
    );

    plist_dpath u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .cmd        (cmd),
        .value      (value),
        .position   (position),
        .stat       (stat),
        .res_status (res_status),
        .res_entry  (res_entry),
        .res_length (res_length),
        .res_last   (res_last)
    );

    assign m_tdata = {2'b00, res_length, res_entry};
    assign m_tuser = res_status;
    assign m_tlast = res_last;

endmodule

`default_nettype wire
